>>> src/ecf_pkg.sv
// Shared types, constants and codes of the Eulerian circuit finder.
`default_nettype none
package ecf_pkg;

	localparam int MAX_NODES = 8;
	localparam int MAX_EDGES = 64;
	localparam int MAX_MULT  = 3;
	localparam int VW        = $clog2(MAX_NODES);
	localparam int MW        = 2;
	localparam int ROW_W     = MAX_NODES * MW;
	localparam int DEG_W     = 5;
	localparam int TOT_W     = 8;
	localparam int CNT_W     = 4;
	localparam int STK_AW    = $clog2(MAX_EDGES);
	localparam int SP_W      = STK_AW + 1;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_START = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ISOLATED = 2'd1;
	localparam logic [1:0] ST_ODD      = 2'd2;
	localparam logic [1:0] ST_TOO_MANY = 2'd3;

	localparam logic REG_NODE_COUNT = 1'b0;

	typedef struct packed {
		logic       opcode;
		logic [2:0] row_vertex;
		logic [2:0] col_vertex;
		logic [1:0] edge_multiplicity;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] from_vertex;
		logic [2:0] to_vertex;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic          is_start;
		logic          in_range;
		logic [VW-1:0] row;
		logic [VW-1:0] col;
		logic [MW-1:0] mult;
	} cmd_t;

endpackage
`default_nettype wire

>>> src/eulerian_circuit_finder.sv
// Top level of the Eulerian circuit finder: register port, front and back ends.
//
// Usage:
//   in channel (in_valid/in_ready/in_word): a load word writes one matrix entry
//   and its mirror; a start word checks the graph and walks the circuit.
//   out channel (out_valid/out_ready/out_word): a start returns either one error
//   word (status nonzero, vertices zero, last set) or one word per circuit edge
//   in pop order, status zero, last set on the final edge.
//   APB port: register 0 holds node_count (reset 8); write it only while idle.
// Timing:
//   A two-entry command queue sits between front and back, so loads are taken
//   one per cycle while the back end is free. A start runs the degree checks
//   (one matrix row a cycle) and then one bound check, then the walk: each
//   pushed edge passes the scan and the second decrement, each pop the scan
//   and a wait for the stack memory read, all run by the single walk sequencer.
// Reset clears the matrix, the queue, the walk control and the output word.
// When the receiver stalls, the back end holds its result word and waits at
// the next word it must send; the queue keeps accepting until it fills.
`default_nettype none
module eulerian_circuit_finder (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire ecf_pkg::in_word_t  in_word,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output ecf_pkg::out_word_t      out_word
);

	logic [3:0]    node_count_q;
	logic          cmd_valid;
	logic          cmd_ready;
	ecf_pkg::cmd_t cmd;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ecf_pkg::REG_NODE_COUNT) ? {28'd0, node_count_q} : 32'd0;

	// Write node_count on the access phase; other addresses are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 4'(ecf_pkg::MAX_NODES);
		end else if (psel && penable && pwrite && pready &&
			(paddr[2] == ecf_pkg::REG_NODE_COUNT)) begin
			node_count_q <= pwdata[3:0];
		end
	end

	ecf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	ecf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_count (node_count_q),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word)
	);

endmodule
`default_nettype wire

>>> src/ecf_front.sv
// Front end: accepts input words, classifies them and queues commands.
`default_nettype none
module ecf_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire ecf_pkg::in_word_t in_word,
	output logic                   cmd_valid,
	input  wire logic              cmd_ready,
	output ecf_pkg::cmd_t          cmd
);

	ecf_pkg::cmd_t cls;
	ecf_pkg::cmd_t fifo_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	// Classify: opcode, range check of the vertices, clamp of the multiplicity.
	always_comb begin
		cls.is_start = (in_word.opcode == ecf_pkg::OP_START);
		cls.in_range = ({1'b0, in_word.row_vertex} < 4'(ecf_pkg::MAX_NODES)) &&
			({1'b0, in_word.col_vertex} < 4'(ecf_pkg::MAX_NODES));
		cls.row = in_word.row_vertex[ecf_pkg::VW-1:0];
		cls.col = in_word.col_vertex[ecf_pkg::VW-1:0];
		if ({1'b0, in_word.edge_multiplicity} > 3'(ecf_pkg::MAX_MULT)) begin
			cls.mult = ecf_pkg::MW'(ecf_pkg::MAX_MULT);
		end else begin
			cls.mult = in_word.edge_multiplicity;
		end
	end

	assign in_ready  = (count_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

>>> src/ecf_back.sv
// Back end: matrix store, degree checks and the stack-based circuit walk.
`default_nettype none
module ecf_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [3:0]         node_count,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	input  wire ecf_pkg::cmd_t      cmd,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output ecf_pkg::out_word_t      out_word
);

	typedef enum logic [2:0] {
		S_IDLE, S_COPY, S_CHKTOT, S_ERR, S_SCAN, S_DEC2, S_POPWAIT
	} state_t;

	state_t                        state_q;
	logic [ecf_pkg::ROW_W-1:0]     lm_q [ecf_pkg::MAX_NODES];
	logic [ecf_pkg::ROW_W-1:0]     wm_q [ecf_pkg::MAX_NODES];
	logic [ecf_pkg::VW-1:0]        stk_mem [2**ecf_pkg::STK_AW];
	logic [ecf_pkg::VW-1:0]        stk_rd_q;
	logic [ecf_pkg::CNT_W-1:0]     idx_q;
	logic [ecf_pkg::TOT_W-1:0]     total_q;
	logic [1:0]                    err_q;
	logic [ecf_pkg::VW-1:0]        top_q;
	logic [ecf_pkg::VW-1:0]        t_q;
	logic [ecf_pkg::VW-1:0]        prev_q;
	logic                          have_prev_q;
	logic [ecf_pkg::SP_W-1:0]      sp_q;
	logic                          out_valid_q;
	ecf_pkg::out_word_t            out_word_q;

	logic [3:0]                    nact;
	logic [ecf_pkg::ROW_W-1:0]     masked;
	logic [ecf_pkg::DEG_W-1:0]     deg;
	logic [ecf_pkg::ROW_W-1:0]     scan_row;
	logic                          found;
	logic [ecf_pkg::VW-1:0]        tsel;
	logic                          out_free;
	logic                          word_load;
	logic                          push;
	logic [ecf_pkg::STK_AW-1:0]    wr_addr;
	logic [ecf_pkg::STK_AW-1:0]    rd_addr;

	always_comb begin
		if (node_count == 4'd0) begin
			nact = 4'd1;
		end else if (node_count > 4'(ecf_pkg::MAX_NODES)) begin
			nact = 4'(ecf_pkg::MAX_NODES);
		end else begin
			nact = node_count;
		end
	end

	// Copy row: drop the diagonal and unused columns, sum the degree.
	always_comb begin
		masked = lm_q[idx_q[ecf_pkg::VW-1:0]];
		deg    = '0;
		for (int j = 0; j < ecf_pkg::MAX_NODES; j++) begin
			if ((4'(j) == idx_q) || (4'(j) >= nact)) begin
				masked[j*ecf_pkg::MW +: ecf_pkg::MW] = '0;
			end
			deg = deg + ecf_pkg::DEG_W'(masked[j*ecf_pkg::MW +: ecf_pkg::MW]);
		end
	end

	// Lowest-numbered neighbor of the stack top.
	always_comb begin
		scan_row = wm_q[top_q];
		found    = 1'b0;
		tsel     = '0;
		for (int j = ecf_pkg::MAX_NODES - 1; j >= 0; j--) begin
			if ((4'(j) < nact) && (scan_row[j*ecf_pkg::MW +: ecf_pkg::MW] != '0)) begin
				found = 1'b1;
				tsel  = ecf_pkg::VW'(j);
			end
		end
	end

	assign out_free  = !out_valid_q || out_ready;
	// A new result word is loaded into the output register this cycle.
	assign word_load = out_free && ((state_q == S_ERR) ||
		((state_q == S_SCAN) && !found &&
		(have_prev_q || (sp_q == ecf_pkg::SP_W'(1)))));
	assign cmd_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign push      = (state_q == S_DEC2);
	assign wr_addr   = ecf_pkg::STK_AW'(sp_q - 1'b1);
	assign rd_addr   = ecf_pkg::STK_AW'(sp_q - 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			stk_mem[wr_addr] <= top_q;
		end
		stk_rd_q <= stk_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_COPY: begin
				wm_q[idx_q[ecf_pkg::VW-1:0]] <= masked;
			end
			S_SCAN: begin
				if (found) begin
					wm_q[top_q][tsel*ecf_pkg::MW +: ecf_pkg::MW] <=
						wm_q[top_q][tsel*ecf_pkg::MW +: ecf_pkg::MW] - 1'b1;
				end
			end
			S_DEC2: begin
				wm_q[t_q][top_q*ecf_pkg::MW +: ecf_pkg::MW] <=
					wm_q[t_q][top_q*ecf_pkg::MW +: ecf_pkg::MW] - 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			for (int i = 0; i < ecf_pkg::MAX_NODES; i++) begin
				lm_q[i] <= '0;
			end
			idx_q       <= '0;
			total_q     <= '0;
			err_q       <= ecf_pkg::ST_OK;
			top_q       <= '0;
			t_q         <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
		end else begin
			if (out_valid_q && out_ready && !word_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (!cmd.is_start) begin
							if (cmd.in_range) begin
								lm_q[cmd.row][cmd.col*ecf_pkg::MW +: ecf_pkg::MW] <= cmd.mult;
								lm_q[cmd.col][cmd.row*ecf_pkg::MW +: ecf_pkg::MW] <= cmd.mult;
							end
						end else begin
							idx_q   <= '0;
							total_q <= '0;
							state_q <= S_COPY;
						end
					end
				end
				S_COPY: begin
					if (deg == '0) begin
						err_q   <= ecf_pkg::ST_ISOLATED;
						state_q <= S_ERR;
					end else if (deg[0]) begin
						err_q   <= ecf_pkg::ST_ODD;
						state_q <= S_ERR;
					end else begin
						total_q <= total_q + ecf_pkg::TOT_W'(deg);
						if (idx_q == nact - 4'd1) begin
							state_q <= S_CHKTOT;
						end else begin
							idx_q <= idx_q + 4'd1;
						end
					end
				end
				S_CHKTOT: begin
					if ((total_q >> 1) > ecf_pkg::TOT_W'(ecf_pkg::MAX_EDGES)) begin
						err_q   <= ecf_pkg::ST_TOO_MANY;
						state_q <= S_ERR;
					end else begin
						top_q       <= '0;
						sp_q        <= ecf_pkg::SP_W'(1);
						have_prev_q <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_ERR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_word_q  <= '{status: err_q, from_vertex: 3'd0,
							to_vertex: 3'd0, last: 1'b1};
						state_q     <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (found) begin
						t_q     <= tsel;
						state_q <= S_DEC2;
					end else if (out_free) begin
						// Pop the top; each pop after the first closes one edge.
						if (have_prev_q || (sp_q == ecf_pkg::SP_W'(1))) begin
							out_valid_q <= 1'b1;
							out_word_q  <= '{status: ecf_pkg::ST_OK,
								from_vertex: have_prev_q ? 3'(prev_q) : 3'd0,
								to_vertex: have_prev_q ? 3'(top_q) : 3'd0,
								last: (sp_q == ecf_pkg::SP_W'(1))};
						end
						prev_q      <= top_q;
						have_prev_q <= 1'b1;
						sp_q        <= sp_q - 1'b1;
						if (sp_q == ecf_pkg::SP_W'(1)) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_POPWAIT;
						end
					end
				end
				S_DEC2: begin
					top_q   <= t_q;
					sp_q    <= sp_q + 1'b1;
					state_q <= S_SCAN;
				end
				S_POPWAIT: begin
					top_q   <= stk_rd_q;
					state_q <= S_SCAN;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> src/ecf_checker.sv
// Port-level checker of the Eulerian circuit finder and its bind.
`default_nettype none
module ecf_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire ecf_pkg::out_word_t out_word
);

	// Hold a stalled result word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word dropped or changed while stalled");

	// An error word ends the command and carries no edge.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.status != ecf_pkg::ST_OK) |->
		out_word.last && (out_word.from_vertex == 3'd0) && (out_word.to_vertex == 3'd0))
		else $error("malformed error word");

	// Walked edges other than the final one never close on themselves.
	a_no_loop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.status == ecf_pkg::ST_OK) && !out_word.last |->
		out_word.from_vertex != out_word.to_vertex)
		else $error("self-loop edge in circuit");

endmodule

bind eulerian_circuit_finder ecf_checker u_ecf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);
`default_nettype wire
